[hw/rtl/fbsc_pkg.sv]
// Shared types and constants of the frustum cull core.
package fbsc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int RADIUS_W   = 31;
  localparam int PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int PROD_W     = 2 * COORD_W;
  // Wide enough for three products plus the scaled offset and radius
  localparam int ACC_BASE_W = (PROD_W > RADIUS_W + FRAC_BITS + 1) ? PROD_W
                                                                 : RADIUS_W + FRAC_BITS + 1;
  localparam int ACC_W      = ACC_BASE_W + 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [PIDX_W-1:0]         pidx_t;
  typedef logic [NUM_PLANES-1:0]     pmask_t;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_BOX    = 2'd2,
    MODE_SPHERE = 2'd3
  } fbsc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } fbsc_state_e;

  // One stored plane: normal and offset
  typedef struct packed {
    coord_t nx;
    coord_t ny;
    coord_t nz;
    coord_t d;
  } plane_t;

  // Box corners, or the sphere center in the min fields
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } corners_t;

  // Tag that travels with a plane read into the distance pipeline
  typedef struct packed {
    logic vld;
    logic last;
    logic is_box;
  } dist_req_t;

  // Per-plane verdict leaving the distance pipeline
  typedef struct packed {
    logic vld;
    logic last;
    logic below;
  } dist_rsp_t;

endpackage

[hw/rtl/frustum_box_sphere_cull_core.sv]
// Top level of the frustum cull core: command control, counters, plane sweep.
//
// Send a transaction by raising start_i while busy_o is low; every transaction
// returns exactly one result, shown for a single cycle with done_o high, and
// the receiver must take it then since the core cannot hold it. Begin frame,
// load plane, and tests issued before all six planes are loaded answer in the
// cycle after acceptance. A box or sphere test against a full frustum sweeps
// the plane store one plane per cycle into a shared dot-product pipeline
// (memory read, multiply, add, sign); busy_o stays high until the verdict of
// the last plane leaves the pipeline, so no new transaction is taken while a
// test is in flight. The plane store comes up unwritten; its content matters
// only once every plane has been loaded.
module frustum_box_sphere_cull_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  plane_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] ext_x_i,
  input  logic signed [31:0] ext_y_i,
  input  logic signed [31:0] ext_z_i,
  input  logic signed [31:0] offset_d_i,
  input  logic [30:0] sphere_radius_i,
  output logic        done_o,
  output logic        visible_o,
  output logic        frustum_valid_o,
  output logic [31:0] tested_count_o,
  output logic [31:0] culled_count_o
);
  import fbsc_pkg::*;

  localparam pidx_t  LAST_IDX  = pidx_t'(NUM_PLANES - 1);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  fbsc_state_e state_q, state_d;
  fbsc_mode_e  mode;
  logic        accept, is_test, full, load_ok, rd_en, culled;
  pidx_t       rd_idx_q;
  logic        rd_vld_q, rd_last_q, box_q, cull_q, done_q, visible_q;
  pmask_t      mask_q;
  logic [31:0] tested_q, culled_q;
  coord_t      px, py, pz;
  coord_t      mx_d, my_d, mz_d;
  logic signed [COORD_W:0] sx, sy, sz;
  corners_t    corners_q;
  logic [RADIUS_W-1:0] radius_q;
  plane_t      wplane, rplane;
  dist_req_t   req;
  dist_rsp_t   rsp;

  assign mode    = fbsc_mode_e'(mode_i);
  assign accept  = start_i && !busy_o;
  assign is_test = (mode == MODE_BOX) || (mode == MODE_SPHERE);
  assign full    = &mask_q;
  assign load_ok = ({29'd0, plane_index_i} < NUM_PLANES);

  // Take coordinates at their working width and saturate the box max corner
  always_comb begin
    px   = coord_t'(pos_x_i[COORD_W-1:0]);
    py   = coord_t'(pos_y_i[COORD_W-1:0]);
    pz   = coord_t'(pos_z_i[COORD_W-1:0]);
    sx   = (COORD_W+1)'(px) + (COORD_W+1)'(coord_t'(ext_x_i[COORD_W-1:0]));
    sy   = (COORD_W+1)'(py) + (COORD_W+1)'(coord_t'(ext_y_i[COORD_W-1:0]));
    sz   = (COORD_W+1)'(pz) + (COORD_W+1)'(coord_t'(ext_z_i[COORD_W-1:0]));
    mx_d = (sx[COORD_W] != sx[COORD_W-1]) ? (sx[COORD_W] ? COORD_MIN : COORD_MAX)
                                          : sx[COORD_W-1:0];
    my_d = (sy[COORD_W] != sy[COORD_W-1]) ? (sy[COORD_W] ? COORD_MIN : COORD_MAX)
                                          : sy[COORD_W-1:0];
    mz_d = (sz[COORD_W] != sz[COORD_W-1]) ? (sz[COORD_W] ? COORD_MIN : COORD_MAX)
                                          : sz[COORD_W-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_test && full) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (rd_idx_q == LAST_IDX) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (rsp.vld && rsp.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    rd_en  = 1'b0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE:  busy_o = 1'b0;
      ST_ISSUE: rd_en  = 1'b1;
      ST_DRAIN: rd_en  = 1'b0;
      default:  busy_o = 1'b0;
    endcase
  end

  // Loads write only while idle and sweeps start in the cycle after acceptance, so no overlap
  assign wplane.nx = px;
  assign wplane.ny = py;
  assign wplane.nz = pz;
  assign wplane.d  = coord_t'(offset_d_i[COORD_W-1:0]);

  fbsc_plane_mem u_plane_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (mode == MODE_LOAD) && load_ok),
    .waddr_i (plane_index_i[PIDX_W-1:0]),
    .wdata_i (wplane),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rplane)
  );

  assign req.vld    = rd_vld_q;
  assign req.last   = rd_last_q;
  assign req.is_box = box_q;

  fbsc_dist_unit u_dist_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .plane_i   (rplane),
    .corners_i (corners_q),
    .radius_i  (radius_q),
    .rsp_o     (rsp)
  );

  assign culled = cull_q || rsp.below;

  // Hold the test operands for the sweep
  always_ff @(posedge clk_i) begin
    if (accept) begin
      corners_q.min_x <= px;
      corners_q.min_y <= py;
      corners_q.min_z <= pz;
      corners_q.max_x <= mx_d;
      corners_q.max_y <= my_d;
      corners_q.max_z <= mz_d;
      radius_q        <= sphere_radius_i;
    end
  end

  // Control, mask and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      box_q     <= 1'b0;
      cull_q    <= 1'b0;
      done_q    <= 1'b0;
      visible_q <= 1'b0;
      mask_q    <= '0;
      tested_q  <= '0;
      culled_q  <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_en;
      rd_last_q <= rd_en && (rd_idx_q == LAST_IDX);
      rd_idx_q  <= rd_en ? rd_idx_q + pidx_t'(1) : '0;
      done_q    <= 1'b0;

      if (accept) begin
        box_q  <= (mode == MODE_BOX);
        cull_q <= 1'b0;
        case (mode)
          MODE_BEGIN: begin
            mask_q   <= '0;
            tested_q <= '0;
            culled_q <= '0;
          end
          MODE_LOAD: begin
            if (load_ok) mask_q <= mask_q | (pmask_t'(1) << plane_index_i);
          end
          MODE_BOX, MODE_SPHERE: begin
            if (tested_q != '1) tested_q <= tested_q + 32'd1;
          end
          default: mask_q <= mask_q;
        endcase
        // Answer at once unless a sweep is needed
        if (!(is_test && full)) begin
          done_q    <= 1'b1;
          visible_q <= 1'b1;
        end
      end

      // Fold per-plane verdicts and finish on the last plane
      if (rsp.vld) begin
        cull_q <= culled;
        if (rsp.last) begin
          done_q    <= 1'b1;
          visible_q <= !culled;
          if (culled && (culled_q != '1)) culled_q <= culled_q + 32'd1;
        end
      end
    end
  end

  assign done_o          = done_q;
  assign visible_o       = visible_q;
  assign frustum_valid_o = full;
  assign tested_count_o  = tested_q;
  assign culled_count_o  = culled_q;

endmodule

[hw/rtl/fbsc_plane_mem.sv]
// Plane store: one write port, one registered read port.
module fbsc_plane_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  fbsc_pkg::pidx_t waddr_i,
  input  fbsc_pkg::plane_t wdata_i,
  input  logic            re_i,
  input  fbsc_pkg::pidx_t raddr_i,
  output fbsc_pkg::plane_t rdata_o
);
  import fbsc_pkg::*;

  plane_t mem_q [NUM_PLANES];
  plane_t rdata_q;

  // Write a plane on load
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, updated only while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fbsc_dist_unit.sv]
// Shared signed-distance pipeline: p-vertex select, three products, sum, sign.
module fbsc_dist_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fbsc_pkg::dist_req_t     req_i,
  input  fbsc_pkg::plane_t        plane_i,
  input  fbsc_pkg::corners_t      corners_i,
  input  logic [fbsc_pkg::RADIUS_W-1:0] radius_i,
  output fbsc_pkg::dist_rsp_t     rsp_o
);
  import fbsc_pkg::*;

  coord_t    vx, vy, vz;
  prod_t     prod_x_d, prod_y_d, prod_z_d;
  prod_t     prod_x_q, prod_y_q, prod_z_q;
  acc_t      rad_ext, d_ext, bias_d, bias_q;
  acc_t      sum_a_d, sum_b_d, sum_a_q, sum_b_q, total;
  dist_req_t p_tag_q, s_tag_q;
  dist_rsp_t rsp_q;

  // Pick the p-vertex per axis for boxes; spheres use the center
  always_comb begin
    vx = corners_i.min_x;
    vy = corners_i.min_y;
    vz = corners_i.min_z;
    if (req_i.is_box) begin
      if (!plane_i.nx[COORD_W-1]) vx = corners_i.max_x;
      if (!plane_i.ny[COORD_W-1]) vy = corners_i.max_y;
      if (!plane_i.nz[COORD_W-1]) vz = corners_i.max_z;
    end
  end

  // Form products and the constant term (radius minus offset, scaled)
  always_comb begin
    prod_x_d = prod_t'(plane_i.nx) * prod_t'(vx);
    prod_y_d = prod_t'(plane_i.ny) * prod_t'(vy);
    prod_z_d = prod_t'(plane_i.nz) * prod_t'(vz);
    rad_ext  = req_i.is_box ? '0 : acc_t'({1'b0, radius_i});
    d_ext    = acc_t'(plane_i.d);
    bias_d   = (rad_ext - d_ext) <<< FRAC_BITS;
  end

  // Reduce to two partial sums, then add the registered pair
  always_comb begin
    sum_a_d = acc_t'(prod_x_q) + acc_t'(prod_y_q);
    sum_b_d = acc_t'(prod_z_q) + bias_q;
    total   = sum_a_q + sum_b_q;
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    prod_z_q <= prod_z_d;
    bias_q   <= bias_d;
    sum_a_q  <= sum_a_d;
    sum_b_q  <= sum_b_d;
  end

  // Advance tags and register the sign of the distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_tag_q <= '0;
      s_tag_q <= '0;
      rsp_q   <= '0;
    end else begin
      p_tag_q     <= req_i;
      s_tag_q     <= p_tag_q;
      rsp_q.vld   <= s_tag_q.vld;
      rsp_q.last  <= s_tag_q.last;
      rsp_q.below <= total[ACC_W-1];
    end
  end

  assign rsp_o = rsp_q;

endmodule

[test/testbench.sv]
// Testbench of the frustum cull core: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import fbsc_pkg::*;

  localparam int ONE  = 65536;       // 1.0 in Q16.16
  localparam int HALF = 100 * ONE;   // half size of the directed cube frustum

  typedef struct packed {
    logic        visible;
    logic        frustum_valid;
    logic [31:0] tested;
    logic [31:0] culled;
  } cull_verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [2:0]  plane_index_i;
  coord_t      pos_x_i, pos_y_i, pos_z_i;
  coord_t      ext_x_i, ext_y_i, ext_z_i;
  coord_t      offset_d_i;
  logic [30:0] sphere_radius_i;
  logic        done_o;
  logic        visible_o;
  logic        frustum_valid_o;
  logic [31:0] tested_count_o;
  logic [31:0] culled_count_o;

  // Predictor state: plane store, loaded mask, frame counters
  coord_t      plane_nx [NUM_PLANES];
  coord_t      plane_ny [NUM_PLANES];
  coord_t      plane_nz [NUM_PLANES];
  coord_t      plane_d  [NUM_PLANES];
  pmask_t      planes_loaded;
  logic [31:0] tests_run;
  logic [31:0] tests_rejected;

  cull_verdict_t cull_results[$];
  int mismatches;
  int items_sent;
  int burst_left;
  int full_tests;
  int culled_tests;
  int partial_tests;

  frustum_box_sphere_cull_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .plane_index_i   (plane_index_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .ext_x_i         (ext_x_i),
    .ext_y_i         (ext_y_i),
    .ext_z_i         (ext_z_i),
    .offset_d_i      (offset_d_i),
    .sphere_radius_i (sphere_radius_i),
    .done_o          (done_o),
    .visible_o       (visible_o),
    .frustum_valid_o (frustum_valid_o),
    .tested_count_o  (tested_count_o),
    .culled_count_o  (culled_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs
  initial begin
    #400_000;
    $display("Test completed with failures");
    $finish;
  end

  // Exact signed distance of a point to plane idx, plus the radius; true when negative
  function automatic logic below_plane(input int idx, input coord_t vx, vy, vz,
                                       input logic [30:0] radius);
    logic signed [95:0] nx, ny, nz, d, x, y, z, r, dist_sum;
    nx = 96'(plane_nx[idx]);
    ny = 96'(plane_ny[idx]);
    nz = 96'(plane_nz[idx]);
    d  = 96'(plane_d[idx]);
    x  = 96'(vx);
    y  = 96'(vy);
    z  = 96'(vz);
    r  = {65'd0, radius};
    dist_sum = nx * x + ny * y + nz * z - (d <<< 16) + (r <<< 16);
    return dist_sum[95];
  endfunction

  // Max corner of a box, saturated to the coordinate range
  function automatic coord_t far_corner(input coord_t lo, input coord_t size);
    logic signed [32:0] sum;
    sum = 33'(lo) + 33'(size);
    if (sum[32] != sum[31]) return sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return sum[31:0];
  endfunction

  // Apply one transaction to the predictor state and return its verdict
  task automatic predict_cull(input fbsc_mode_e mode, input logic [2:0] pidx,
                              input coord_t px, py, pz, ex, ey, ez, od,
                              input logic [30:0] rad, output cull_verdict_t res);
    logic   vis;
    coord_t mx, my, mz;
    vis = 1'b1;
    case (mode)
      MODE_BEGIN: begin
        planes_loaded  = '0;
        tests_run      = '0;
        tests_rejected = '0;
      end
      MODE_LOAD: begin
        // Out-of-range indexes write nothing
        if (pidx < NUM_PLANES) begin
          plane_nx[pidx]      = px;
          plane_ny[pidx]      = py;
          plane_nz[pidx]      = pz;
          plane_d[pidx]       = od;
          planes_loaded[pidx] = 1'b1;
        end
      end
      default: begin
        if (tests_run != '1) tests_run++;
        if (&planes_loaded) begin
          mx = far_corner(px, ex);
          my = far_corner(py, ey);
          mz = far_corner(pz, ez);
          // First culling plane decides
          for (int i = 0; i < NUM_PLANES && vis; i++) begin
            if (mode == MODE_BOX) begin
              vis = !below_plane(i, plane_nx[i][31] ? px : mx, plane_ny[i][31] ? py : my,
                                 plane_nz[i][31] ? pz : mz, '0);
            end else begin
              vis = !below_plane(i, px, py, pz, rad);
            end
          end
          if (!vis && tests_rejected != '1) tests_rejected++;
          full_tests++;
          if (!vis) culled_tests++;
        end else begin
          partial_tests++;
        end
      end
    endcase
    res.visible       = vis;
    res.frustum_valid = &planes_loaded;
    res.tested        = tests_run;
    res.culled        = tests_rejected;
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want, got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Check each result against the oldest pending verdict, then record accepted transactions
  always @(posedge clk_i) begin : result_check
    cull_verdict_t got;
    cull_verdict_t want;
    cull_verdict_t next;
    if (rst_ni) begin
      if (done_o) begin
        got = '{visible_o, frustum_valid_o, tested_count_o, culled_count_o};
        if (cull_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no pending transaction", $time);
        end else begin
          want = cull_results.pop_front();
          if (got.visible !== want.visible)
            note_mismatch("visible", 32'(want.visible), 32'(got.visible));
          if (got.frustum_valid !== want.frustum_valid)
            note_mismatch("frustum_valid", 32'(want.frustum_valid), 32'(got.frustum_valid));
          if (got.tested !== want.tested)
            note_mismatch("tested_count", want.tested, got.tested);
          if (got.culled !== want.culled)
            note_mismatch("culled_count", want.culled, got.culled);
        end
      end
      if (start_i && !busy_o) begin
        predict_cull(fbsc_mode_e'(mode_i), plane_index_i, pos_x_i, pos_y_i, pos_z_i,
                     ext_x_i, ext_y_i, ext_z_i, offset_d_i, sphere_radius_i, next);
        cull_results.push_back(next);
      end
    end
  end

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t rand_span(input int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Drive one transaction and hold it until accepted; idle between bursts
  task automatic send_cmd(input fbsc_mode_e mode, input logic [2:0] pidx,
                          input coord_t px, py, pz, ex, ey, ez, od,
                          input logic [30:0] rad);
    mode_i          <= mode;
    plane_index_i   <= pidx;
    pos_x_i         <= px;
    pos_y_i         <= py;
    pos_z_i         <= pz;
    ext_x_i         <= ex;
    ext_y_i         <= ey;
    ext_z_i         <= ez;
    offset_d_i      <= od;
    sphere_radius_i <= rad;
    start_i         <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Hold off the sender until every pending result has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (cull_results.size() != 0);
  endtask

  task automatic begin_frame();
    send_cmd(MODE_BEGIN, 3'($urandom()), any_coord(), any_coord(), any_coord(), any_coord(),
             any_coord(), any_coord(), any_coord(), 31'($urandom()));
  endtask

  task automatic load_plane(input logic [2:0] idx, input coord_t nx, ny, nz, d);
    send_cmd(MODE_LOAD, idx, nx, ny, nz, any_coord(), any_coord(), any_coord(), d,
             31'($urandom()));
  endtask

  task automatic test_box(input coord_t px, py, pz, ex, ey, ez);
    send_cmd(MODE_BOX, 3'($urandom()), px, py, pz, ex, ey, ez, any_coord(), 31'($urandom()));
  endtask

  task automatic test_sphere(input coord_t px, py, pz, input logic [30:0] rad);
    send_cmd(MODE_SPHERE, 3'($urandom()), px, py, pz, any_coord(), any_coord(), any_coord(),
             any_coord(), rad);
  endtask

  // Load an axis-aligned cube frustum, optionally tilted, shuffled or missing one plane
  task automatic load_cube(input int half, input int tilt, input bit shuffle, input bit skip_one);
    int     order [NUM_PLANES];
    int     j, tmp, ax;
    coord_t n [3];
    for (int k = 0; k < NUM_PLANES; k++) order[k] = k;
    if (shuffle) begin
      for (int k = NUM_PLANES - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    for (int k = 0; k < (skip_one ? NUM_PLANES - 1 : NUM_PLANES); k++) begin
      ax = order[k] / 2;
      for (int a = 0; a < 3; a++) n[a] = (tilt > 0) ? rand_span(tilt) : '0;
      n[ax] = (order[k] % 2) ? n[ax] - ONE : n[ax] + ONE;
      load_plane(3'(order[k]), n[0], n[1], n[2], -half);
      // Sprinkle loads to indexes that do not exist
      if (shuffle && $urandom_range(0, 9) == 0) begin
        load_plane(3'($urandom_range(NUM_PLANES, 7)), any_coord(), any_coord(), any_coord(),
                   any_coord());
      end
    end
  endtask

  // Boxes and spheres scattered around a frustum of the given half size
  task automatic random_tests(input int half, input int count);
    coord_t sx, sy, sz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1)) test_box(any_coord(), any_coord(), any_coord(),
                                           any_coord(), any_coord(), any_coord());
        else test_sphere(any_coord(), any_coord(), any_coord(), 31'($urandom()));
      end else if ($urandom_range(0, 1)) begin
        sx = ($urandom_range(0, 7) == 0) ? rand_span(half) : coord_t'($urandom_range(0, half));
        sy = ($urandom_range(0, 7) == 0) ? rand_span(half) : coord_t'($urandom_range(0, half));
        sz = ($urandom_range(0, 7) == 0) ? rand_span(half) : coord_t'($urandom_range(0, half));
        test_box(rand_span(2 * half), rand_span(2 * half), rand_span(2 * half), sx, sy, sz);
      end else begin
        test_sphere(rand_span(2 * half), rand_span(2 * half), rand_span(2 * half),
                    31'($urandom_range(0, half)));
      end
    end
  endtask

  // Tests before the frustum is complete, ignored indexes, partial loads
  task automatic test_before_frustum();
    begin_frame();
    test_box(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
    test_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 31'h7FFF_FFFF);
    load_plane(3'd6, ONE, ONE, ONE, 32'sh7FFF_FFFF);
    load_plane(3'd7, -ONE, -ONE, -ONE, 32'sh7FFF_FFFF);
    load_cube(HALF, 0, 1'b0, 1'b1);
    test_sphere(1000 * ONE, 0, 0, '0);
  endtask

  // Known geometry against the cube of half size 100
  task automatic test_cube_geometry();
    load_plane(3'd5, 0, 0, -ONE, -HALF);
    test_box(-10 * ONE, -10 * ONE, -10 * ONE, 20 * ONE, 20 * ONE, 20 * ONE);
    test_box(150 * ONE, 0, 0, 10 * ONE, 10 * ONE, 10 * ONE);
    test_box(90 * ONE, -200 * ONE, -5 * ONE, 20 * ONE, 400 * ONE, 10 * ONE);
    // negative size: max corner lies below the min corner
    test_box(150 * ONE, 0, 0, -100 * ONE, 0, 0);
    // empty box exactly on a face
    test_box(-HALF, 0, 0, 0, 0, 0);
    // max corner saturates high on x and low on y
    test_box(32'sh7FFF_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    test_sphere(0, 0, 0, '0);
    // touching the face, then one step short of it
    test_sphere(110 * ONE, 0, 0, 31'(10 * ONE));
    test_sphere(110 * ONE, 0, 0, 31'(10 * ONE - 1));
    test_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 31'h7FFF_FFFF);
  endtask

  // Full-scale normals and offsets, reload of a set plane, frame restart
  task automatic test_extreme_planes();
    load_plane(3'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    test_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    load_plane(3'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    test_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    test_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    begin_frame();
    test_box(0, 0, 0, 0, 0, 0);
  endtask

  // Frames of plane loads followed by tests, with noise and drained pauses
  task automatic test_random_frames(input int target);
    int first;
    int half;
    int kind;
    first = items_sent;
    while (items_sent - first < target) begin
      if ($urandom_range(0, 7) != 0) begin_frame();
      half = $urandom_range(1, 2000) * ONE;
      if ($urandom_range(0, 3) == 0) random_tests(half, 2);
      kind = $urandom_range(0, 5);
      if (kind == 0) begin
        for (int k = 0; k < NUM_PLANES; k++) begin
          load_plane(3'(k), any_coord(), any_coord(), any_coord(), any_coord());
        end
      end else begin
        load_cube(half, (kind == 1) ? 0 : $urandom_range(0, ONE / 2), 1'b1,
                  $urandom_range(0, 6) == 0);
      end
      random_tests(half, $urandom_range(3, 20));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    mismatches      = 0;
    items_sent      = 0;
    burst_left      = 0;
    full_tests      = 0;
    culled_tests    = 0;
    partial_tests   = 0;
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    mode_i          <= MODE_BEGIN;
    plane_index_i   <= '0;
    pos_x_i         <= '0;
    pos_y_i         <= '0;
    pos_z_i         <= '0;
    ext_x_i         <= '0;
    ext_y_i         <= '0;
    ext_z_i         <= '0;
    offset_d_i      <= '0;
    sphere_radius_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_frustum();
    test_cube_geometry();
    test_extreme_planes();
    wait_drained();
    test_random_frames(500);

    // Drain and let the pipeline settle
    start_i <= 1'b0;
    while (cull_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d transactions; %0d tests against a full frustum (%0d culled),",
             items_sent, full_tests, culled_tests);
    $display("%0d tests before the frustum was complete, %0d mismatches.",
             partial_tests, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
